// File: hw/rtl/vprs_pkg.sv
// Shared types, codes and constants of the VIP priority request scheduler.
// No dependencies; every other file of the block imports this package.
package vprs_pkg;

    localparam int unsigned CMD_W    = 3;
    localparam int unsigned PID_W    = 22;
    localparam int unsigned TAG_W    = 16;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned REG_W    = 10;
    localparam int unsigned HOLD_W   = 11;
    localparam int unsigned ENT_W    = PID_W + 1;
    localparam int unsigned CFG_AW   = 1;
    localparam int unsigned S_DATA_W = 48;
    localparam int unsigned M_DATA_W = 24;

    localparam int unsigned QUEUE_DEPTH_DEF = 64;
    localparam int unsigned BUCKETS_DEF     = 16;
    localparam int unsigned WAYS_DEF        = 4;

    localparam logic [REG_W-1:0] HOLDOFF_RST = 10'd20;
    localparam logic [REG_W-1:0] RESUME_RST  = 10'd30;

    typedef enum logic [CMD_W-1:0] {
        CMD_SUBMIT   = 3'd0,
        CMD_DISPATCH = 3'd1,
        CMD_TICK     = 3'd2,
        CMD_ADD      = 3'd3,
        CMD_REMOVE   = 3'd4,
        CMD_CLEAR    = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_QFULL = 2'd1,
        ST_BFULL = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [CFG_AW-1:0] {
        REG_HOLDOFF = 1'b0,
        REG_RESUME  = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic single;
    } q_stat_t;

    typedef struct packed {
        logic hit;
        logic has_free;
    } tbl_flags_t;

    function automatic int unsigned addr_bits(int unsigned depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

// File: hw/rtl/vprs_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Depends on vprs_pkg for the address width helper.
module vprs_ram
    import vprs_pkg::*;
#(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 64,
    localparam int unsigned AW   = addr_bits(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hw/rtl/vprs_queue.sv
// Ring FIFO of request tags: head, tail and fill count around one vprs_ram.
// Depends on vprs_pkg and vprs_ram.
module vprs_queue
    import vprs_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_req,
    input  logic             push,
    input  logic [TAG_W-1:0] push_data,
    input  logic             pop,
    output logic [TAG_W-1:0] head_data,
    output q_stat_t          stat
);

    localparam int unsigned AW = addr_bits(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
        begin
            tail_next  = (tail_reg == LAST) ? '0 : tail_reg + AW'(1);
            count_next = count_reg + CW'(1);
        end
        else if (pop)
        begin
            head_next  = (head_reg == LAST) ? '0 : head_reg + AW'(1);
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    assign stat.empty  = (count_reg == '0);
    assign stat.full   = (count_reg == CW'(DEPTH));
    assign stat.single = (count_reg == CW'(1));

    vprs_ram #(
        .WIDTH (TAG_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (push),
        .waddr (tail_reg),
        .wdata (push_data),
        .re    (rd_req),
        .raddr (head_reg),
        .rdata (head_data)
    );

endmodule

// File: hw/rtl/vprs_hash.sv
// Bucket hash: pid mod BUCKETS by reciprocal multiply, then a constant multiply-subtract.
// Depends on vprs_pkg.
module vprs_hash
    import vprs_pkg::*;
#(
    parameter int unsigned BUCKETS = BUCKETS_DEF,
    localparam int unsigned BKT_AW = addr_bits(BUCKETS)
) (
    input  logic              clk,
    input  logic              load,
    input  logic [PID_W-1:0]  pid_in,
    output logic [BKT_AW-1:0] bucket
);

    // Exact quotient for any 22-bit pid: scale by 2^(PID_W + ceil(log2 BUCKETS)).
    localparam int unsigned SHIFT      = PID_W + $clog2(BUCKETS);
    localparam logic [63:0] SCALE      = 64'd1 << SHIFT;
    localparam logic [63:0] RECIP_WIDE = (SCALE + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
    localparam logic [PID_W:0] RECIP   = RECIP_WIDE[PID_W:0];
    localparam int unsigned PROD_W     = 2 * PID_W + 1;

    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] quot_wide;
    logic [PID_W-1:0]  pid_reg;
    logic [PID_W-1:0]  quot_reg;
    logic [31:0]       quot_times;
    logic [31:0]       rem;

    assign prod      = PROD_W'(pid_in) * PROD_W'(RECIP);
    assign quot_wide = prod >> SHIFT;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pid_reg  <= pid_in;
            quot_reg <= quot_wide[PID_W-1:0];
        end
    end

    assign quot_times = 32'(quot_reg) * 32'(BUCKETS);
    assign rem        = 32'(pid_reg) - quot_times;
    assign bucket     = rem[BKT_AW-1:0];

endmodule

// File: hw/rtl/vprs_table.sv
// Bucket row lookup of the VIP set: way match, first free way and updated rows.
// Depends on vprs_pkg.
module vprs_table
    import vprs_pkg::*;
#(
    parameter int unsigned WAYS = WAYS_DEF
) (
    input  logic [WAYS*ENT_W-1:0] row,
    input  logic [PID_W-1:0]      pid,
    output tbl_flags_t            flags,
    output logic [WAYS*ENT_W-1:0] add_row,
    output logic [WAYS*ENT_W-1:0] del_row
);

    localparam int unsigned WAY_AW = addr_bits(WAYS);

    logic [WAYS-1:0]   match;
    logic [WAYS-1:0]   free;
    logic [WAY_AW-1:0] free_idx;
    logic [ENT_W-1:0]  ent;

    always_comb
    begin
        match    = '0;
        free     = '0;
        free_idx = '0;
        ent      = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            ent      = row[w*ENT_W +: ENT_W];
            match[w] = ent[ENT_W-1] && (ent[PID_W-1:0] == pid);
            free[w]  = !ent[ENT_W-1];
        end
        // lowest free way wins
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (free[w])
            begin
                free_idx = WAY_AW'(w);
            end
        end
        add_row = row;
        del_row = row;
        for (int w = 0; w < WAYS; w++)
        begin
            if (free_idx == WAY_AW'(w))
            begin
                add_row[w*ENT_W +: ENT_W] = {1'b1, pid};
            end
            if (match[w])
            begin
                del_row[w*ENT_W +: ENT_W] = '0;
            end
        end
    end

    assign flags.hit      = |match;
    assign flags.has_free = |free;

endmodule

// File: hw/rtl/vip_priority_request_scheduler_top.sv
// VIP priority request scheduler, top level: sequencer, registers and memories.
// Depends on vprs_pkg, vprs_hash, vprs_table, vprs_queue and vprs_ram.
//
// Takes one command per input transfer (submit, dispatch, tick, add VIP pid, remove VIP
// pid, clear VIP set) and returns exactly one result transfer for it. Each item passes
// the accept, read and decide states in turn: on accept the reciprocal product of the
// bucket hash is registered, the read state finishes pid mod BUCKETS and reads the
// bucket row and both queue heads from their synchronous memories, and the decide state
// decides, writes back and loads the output register. Items are handled one at a time,
// so every write lands before the next item's reads. The output register lets the next
// item be accepted while a result still waits; the block only holds in its decide state
// if that register is still full. After reset and after every clear-set command a
// clearing pass writes one bucket row per cycle over all BUCKETS rows, during which no
// item is accepted; configuration writes are taken at any time.
module vip_priority_request_scheduler_top
    import vprs_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int unsigned BUCKETS     = BUCKETS_DEF,
    parameter int unsigned WAYS        = WAYS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    // request channel
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // cmd[2:0], pid[24:3], tag[40:25], force_req[41]
    // result channel
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,  // status[1:0], grant_valid[2], grant_tag[18:3],
                                          // grant_from_vip[19], work_pending[20], wake[21]
    // configuration writes
    input  logic                cfg_we,
    input  logic [CFG_AW-1:0]   cfg_addr,
    input  logic [REG_W-1:0]    cfg_wdata
);

    localparam int unsigned BKT_AW = addr_bits(BUCKETS);
    localparam int unsigned ROW_W  = WAYS * ENT_W;
    localparam logic [BKT_AW-1:0] LAST_BKT = BKT_AW'(BUCKETS - 1);

    // ---------------------------------------------------------------- registers
    state_t             state_reg, state_next;
    logic [BKT_AW-1:0]  clr_idx_reg, clr_idx_next;
    logic [CMD_W-1:0]   cmd_reg;
    logic [PID_W-1:0]   pid_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic               force_reg;
    logic [REG_W-1:0]   holdoff_ticks_reg;
    logic [REG_W-1:0]   resume_ticks_reg;
    logic [HOLD_W-1:0]  hold_reg, hold_next;
    logic [REG_W-1:0]   resume_reg, resume_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg;

    // ---------------------------------------------------------------- control
    logic               accept;
    logic               rd_issue;
    logic               commit;
    logic               clearing;

    // ---------------------------------------------------------------- datapath
    logic [BKT_AW-1:0]  bucket;
    logic [ROW_W-1:0]   row_rdata;
    logic [ROW_W-1:0]   add_row;
    logic [ROW_W-1:0]   del_row;
    logic [ROW_W-1:0]   row_wdata;
    logic [BKT_AW-1:0]  row_waddr;
    logic               row_we;
    tbl_flags_t         tflags;
    q_stat_t            vq_stat, nq_stat;
    logic [TAG_W-1:0]   vq_head, nq_head;
    logic               vq_push, nq_push, vq_pop, nq_pop;
    logic               tbl_write;
    status_t            status;
    logic               grant_valid;
    logic [TAG_W-1:0]   grant_tag;
    logic               grant_from_vip;
    logic               wake;
    logic               vq_busy_after, nq_busy_after;
    logic               work_pending;
    cmd_t               cmd;

    assign cmd = cmd_t'(cmd_reg);

    // ---------------------------------------------------------------- sequencer
    always_comb
    begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_idx_reg == LAST_BKT)
                begin
                    clr_idx_next = '0;
                    state_next   = S_IDLE;
                end
                else
                begin
                    clr_idx_next = clr_idx_reg + BKT_AW'(1);
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = (cmd == CMD_CLEAR) ? S_CLEAR : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        rd_issue = 1'b0;
        commit   = 1'b0;
        clearing = 1'b0;
        unique case (state_reg)
            S_CLEAR: clearing = 1'b1;
            S_IDLE:  s_tready = 1'b1;
            S_READ:  rd_issue = 1'b1;
            S_EXEC:  commit   = !m_tvalid_reg || m_tready;
            default: s_tready = 1'b0;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    // ---------------------------------------------------------------- decide
    always_comb
    begin
        status         = ST_DONE;
        grant_valid    = 1'b0;
        grant_tag      = '0;
        grant_from_vip = 1'b0;
        wake           = 1'b0;
        vq_push        = 1'b0;
        nq_push        = 1'b0;
        vq_pop         = 1'b0;
        nq_pop         = 1'b0;
        tbl_write      = 1'b0;
        hold_next      = hold_reg;
        resume_next    = resume_reg;
        unique case (cmd)
            CMD_SUBMIT:
            begin
                // route by VIP membership; drop on a full queue
                if (tflags.hit)
                begin
                    if (vq_stat.full)
                        status = ST_QFULL;
                    else
                        vq_push = commit;
                end
                else
                begin
                    if (nq_stat.full)
                        status = ST_QFULL;
                    else
                        nq_push = commit;
                end
            end
            CMD_DISPATCH:
            begin
                if (!vq_stat.empty)
                begin
                    grant_valid    = 1'b1;
                    grant_tag      = vq_head;
                    grant_from_vip = 1'b1;
                    vq_pop         = commit;
                    hold_next      = {1'b0, holdoff_ticks_reg} + HOLD_W'(1);
                    resume_next    = resume_ticks_reg;
                end
                else if ((force_reg || hold_reg == '0) && !nq_stat.empty)
                begin
                    grant_valid = 1'b1;
                    grant_tag   = nq_head;
                    nq_pop      = commit;
                end
                else
                begin
                    status = ST_EMPTY;
                end
            end
            CMD_TICK:
            begin
                if (hold_reg != '0)
                    hold_next = hold_reg - HOLD_W'(1);
                if (resume_reg != '0)
                begin
                    resume_next = resume_reg - REG_W'(1);
                    wake        = (resume_reg == REG_W'(1));
                end
            end
            CMD_ADD:
            begin
                // pid 0 and pids already present are ignored
                if (pid_reg != '0 && !tflags.hit)
                begin
                    if (tflags.has_free)
                        tbl_write = 1'b1;
                    else
                        status = ST_BFULL;
                end
            end
            CMD_REMOVE:
            begin
                tbl_write = tflags.hit;
            end
            CMD_CLEAR:
            begin
                tbl_write = 1'b0;
            end
            default:
            begin
                status = ST_DONE;
            end
        endcase
    end

    // queue occupancy after this item; push and pop never coincide
    assign vq_busy_after = vq_push || (!vq_stat.empty && !(vq_pop && vq_stat.single));
    assign nq_busy_after = nq_push || (!nq_stat.empty && !(nq_pop && nq_stat.single));
    assign work_pending  = vq_busy_after || (hold_next == '0 && nq_busy_after);

    // ---------------------------------------------------------------- table write port
    always_comb
    begin
        row_we    = 1'b0;
        row_waddr = bucket;
        row_wdata = '0;
        if (clearing)
        begin
            row_we    = 1'b1;
            row_waddr = clr_idx_reg;
        end
        else if (commit && tbl_write)
        begin
            row_we    = 1'b1;
            row_wdata = (cmd == CMD_ADD) ? add_row : del_row;
        end
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_CLEAR;
            clr_idx_reg       <= '0;
            holdoff_ticks_reg <= HOLDOFF_RST;
            resume_ticks_reg  <= RESUME_RST;
            hold_reg          <= '0;
            resume_reg        <= '0;
            m_tvalid_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_idx_reg  <= clr_idx_next;
            m_tvalid_reg <= m_tvalid_next;
            if (commit)
            begin
                hold_reg   <= hold_next;
                resume_reg <= resume_next;
            end
            if (cfg_we)
            begin
                if (cfg_addr == REG_HOLDOFF)
                    holdoff_ticks_reg <= cfg_wdata;
                if (cfg_addr == REG_RESUME)
                    resume_ticks_reg <= cfg_wdata;
            end
        end
    end

    // hold the item; drop the result into the output register on commit
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= s_tdata[2:0];
            pid_reg   <= s_tdata[24:3];
            tag_reg   <= s_tdata[40:25];
            force_reg <= s_tdata[41];
        end
        if (commit)
        begin
            m_tdata_reg <= {2'b00, wake, work_pending, grant_from_vip, grant_tag,
                            grant_valid, status};
        end
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (commit)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------------------------------------------------------- units
    vprs_hash #(
        .BUCKETS (BUCKETS)
    ) u_hash (
        .clk    (clk),
        .load   (accept),
        .pid_in (s_tdata[24:3]),
        .bucket (bucket)
    );

    vprs_ram #(
        .WIDTH (ROW_W),
        .DEPTH (BUCKETS)
    ) u_table_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .re    (rd_issue),
        .raddr (bucket),
        .rdata (row_rdata)
    );

    vprs_table #(
        .WAYS (WAYS)
    ) u_table (
        .row     (row_rdata),
        .pid     (pid_reg),
        .flags   (tflags),
        .add_row (add_row),
        .del_row (del_row)
    );

    vprs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_vip_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_req    (rd_issue),
        .push      (vq_push),
        .push_data (tag_reg),
        .pop       (vq_pop),
        .head_data (vq_head),
        .stat      (vq_stat)
    );

    vprs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_normal_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_req    (rd_issue),
        .push      (nq_push),
        .push_data (tag_reg),
        .pop       (nq_pop),
        .head_data (nq_head),
        .stat      (nq_stat)
    );

    // ---------------------------------------------------------------- assertions
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (vq_pop || nq_pop) |-> !(vq_pop && vq_stat.empty) && !(nq_pop && nq_stat.empty))
        else $error("queue popped while empty");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (vq_push || nq_push) |-> !(vq_push && vq_stat.full) && !(nq_push && nq_stat.full))
        else $error("queue pushed while full");

    a_clear_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && cmd == CMD_CLEAR) |=> (state_reg == S_CLEAR && clr_idx_reg == '0))
        else $error("clear pass did not start at row zero");

    a_result_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && m_tready && !commit) |=> !m_tvalid_reg)
        else $error("taken result not dropped");

    a_hold_range: assert property (@(posedge clk) disable iff (!rst_n)
        hold_reg <= HOLD_W'(1024))
        else $error("holdoff counter out of range");

endmodule

// File: bench/vprs_result_checker.sv
// Result checker for the VIP priority request scheduler: mirrors the two request queues,
// the hashed VIP set and the holdoff/resume counters, and compares every result transfer.
// Depends on vprs_pkg for widths, command, status and register codes.
module vprs_result_checker
    import vprs_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int unsigned BUCKETS     = BUCKETS_DEF,
    parameter int unsigned WAYS        = WAYS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,
    input  logic                cfg_we,
    input  logic [CFG_AW-1:0]   cfg_addr,
    input  logic [REG_W-1:0]    cfg_wdata,
    output int                  fail_count,
    output int                  results_due
);

    timeunit 1ns;
    timeprecision 1ps;

    // laid out as on m_tdata, highest field first
    typedef struct packed {
        logic             wake;
        logic             work_pending;
        logic             grant_from_vip;
        logic [TAG_W-1:0] grant_tag;
        logic             grant_valid;
        status_t          status;
    } sched_result_t;

    logic [TAG_W-1:0]  vip_tags[$];
    logic [TAG_W-1:0]  normal_tags[$];
    logic [ENT_W-1:0]  vip_set[BUCKETS*WAYS];
    logic [HOLD_W-1:0] holdoff_left;
    logic [REG_W-1:0]  resume_left;
    logic [REG_W-1:0]  holdoff_cfg;
    logic [REG_W-1:0]  resume_cfg;
    sched_result_t     due_results[$];
    int                fails;

    function automatic int find_vip(logic [PID_W-1:0] pid);
        int base;
        base = (pid % BUCKETS) * WAYS;
        for (int w = 0; w < WAYS; w++)
        begin
            if (vip_set[base+w][PID_W] && vip_set[base+w][PID_W-1:0] == pid)
            begin
                return base + w;
            end
        end
        return -1;
    endfunction

    function automatic status_t add_vip(logic [PID_W-1:0] pid);
        int base;
        base = (pid % BUCKETS) * WAYS;
        if (pid == '0 || find_vip(pid) >= 0)
        begin
            return ST_DONE;
        end
        for (int w = 0; w < WAYS; w++)
        begin
            if (!vip_set[base+w][PID_W])
            begin
                vip_set[base+w] = {1'b1, pid};
                return ST_DONE;
            end
        end
        return ST_BFULL;
    endfunction

    // advance the mirrored state by one command and return its result
    function automatic sched_result_t schedule_command(logic [S_DATA_W-1:0] d);
        logic [CMD_W-1:0] op;
        logic [PID_W-1:0] pid;
        logic [TAG_W-1:0] tag;
        logic             force_req;
        sched_result_t    r;
        int               slot;
        op        = d[2:0];
        pid       = d[24:3];
        tag       = d[40:25];
        force_req = d[41];
        r         = '0;
        r.status  = ST_DONE;
        case (op)
            CMD_SUBMIT:
            begin
                if (find_vip(pid) >= 0)
                begin
                    if (vip_tags.size() < QUEUE_DEPTH)
                        vip_tags.push_back(tag);
                    else
                        r.status = ST_QFULL;
                end
                else if (normal_tags.size() < QUEUE_DEPTH)
                begin
                    normal_tags.push_back(tag);
                end
                else
                begin
                    r.status = ST_QFULL;
                end
            end
            CMD_DISPATCH:
            begin
                if (vip_tags.size() != 0)
                begin
                    r.grant_tag      = vip_tags.pop_front();
                    r.grant_valid    = 1'b1;
                    r.grant_from_vip = 1'b1;
                    holdoff_left     = {1'b0, holdoff_cfg} + 11'd1;
                    resume_left      = resume_cfg;
                end
                else if ((force_req || holdoff_left == '0) && normal_tags.size() != 0)
                begin
                    r.grant_tag   = normal_tags.pop_front();
                    r.grant_valid = 1'b1;
                end
                else
                begin
                    r.status = ST_EMPTY;
                end
            end
            CMD_TICK:
            begin
                if (holdoff_left != '0)
                    holdoff_left--;
                if (resume_left != '0)
                begin
                    resume_left--;
                    r.wake = (resume_left == '0);
                end
            end
            CMD_ADD:
            begin
                r.status = add_vip(pid);
            end
            CMD_REMOVE:
            begin
                slot = find_vip(pid);
                if (slot >= 0)
                    vip_set[slot] = '0;
            end
            CMD_CLEAR:
            begin
                foreach (vip_set[i])
                    vip_set[i] = '0;
            end
            default:
            begin
            end
        endcase
        r.work_pending = vip_tags.size() != 0 || (holdoff_left == '0 && normal_tags.size() != 0);
        return r;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sched_result_t want;
        sched_result_t got;
        if (!rst_n)
        begin
            vip_tags.delete();
            normal_tags.delete();
            due_results.delete();
            foreach (vip_set[i])
                vip_set[i] = '0;
            holdoff_left = '0;
            resume_left  = '0;
            holdoff_cfg  = HOLDOFF_RST;
            resume_cfg   = RESUME_RST;
            fails        = 0;
            fail_count  <= 0;
            results_due <= 0;
        end
        else
        begin
            // results first: a result never belongs to a command taken at the same edge
            if (m_tvalid && m_tready)
            begin
                got = sched_result_t'(m_tdata[21:0]);
                if (due_results.size() == 0)
                begin
                    $error("result transfer with no command outstanding");
                    fails++;
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("grant_valid", want.grant_valid, got.grant_valid);
                    check_field("grant_tag", want.grant_tag, got.grant_tag);
                    check_field("grant_from_vip", want.grant_from_vip, got.grant_from_vip);
                    check_field("work_pending", want.work_pending, got.work_pending);
                    check_field("wake", want.wake, got.wake);
                end
            end
            if (s_tvalid && s_tready)
                due_results.push_back(schedule_command(s_tdata));
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_HOLDOFF: holdoff_cfg = cfg_wdata;
                    REG_RESUME:  resume_cfg  = cfg_wdata;
                    default:
                    begin
                    end
                endcase
            end
            fail_count  <= fails;
            results_due <= due_results.size();
        end
    end

endmodule

// File: bench/vip_priority_request_scheduler_top_test.sv
// Testbench top for the VIP priority request scheduler: clock, reset, command stimulus,
// result back-pressure and the verdict. Depends on vprs_pkg, the scheduler top level
// and vprs_result_checker, which does all prediction and comparison.
module vip_priority_request_scheduler_top_test
    import vprs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LONG_HOLD  = 300;   // cycles the result side refuses in the pressure phase
    localparam int PHASE_CMDS = 55;    // random commands per register setting

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic                m_tready  = 1'b0;
    logic                cfg_we    = 1'b0;
    cfg_reg_t            cfg_addr  = REG_HOLDOFF;
    logic [REG_W-1:0]    cfg_wdata = '0;
    wire                 s_tready;
    wire                 m_tvalid;
    wire  [M_DATA_W-1:0] m_tdata;
    int                  fail_count;
    int                  results_due;

    // idling switches, read by the sender task and the result-side process
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;

    // long hold-off request: bumped by the stimulus, acted on by the result side
    int hold_req  = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int stall_left = 0;

    int cmds_sent = 0;
    int settings_run = 0;

    // pids that share bucket 5, the top pid, and two pids in bucket 0 / 1
    logic [PID_W-1:0] pid_pool[8] = '{22'd5, 22'd21, 22'd37, 22'd53, 22'd69,
                                      22'h3FFFFF, 22'd1, 22'd16};

    vip_priority_request_scheduler_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // cmd, pid, tag, force_req from bit 0 up
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // status, grant_valid, grant_tag, grant_from_vip,
                                 // work_pending, wake from bit 0 up
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    vprs_result_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (fail_count),
        .results_due (results_due)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Result side: a long hold-off when asked, otherwise random stall bursts while idling
    // is enabled, otherwise always ready.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD - 1;
            m_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (rx_idle_en && $urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(0, 5);
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Offer one command and hold it until the transfer; optionally idle first.
    // Returns at the edge of the transfer with tvalid still high.
    task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [PID_W-1:0] pid,
                            logic [TAG_W-1:0] tag, logic force_req);
        int gap;
        if (tx_idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, force_req, tag, pid, cmd};
        do
            @(posedge clk);
        while (!s_tready);
        cmds_sent++;
    endtask

    // Mostly meaningful traffic on a small pid pool, with a share of random pids.
    task automatic send_random_cmd();
        int unsigned      r;
        logic [CMD_W-1:0] cmd;
        logic [PID_W-1:0] pid;
        r = $urandom_range(0, 99);
        if (r < 30)
            cmd = CMD_SUBMIT;
        else if (r < 60)
            cmd = CMD_DISPATCH;
        else if (r < 84)
            cmd = CMD_TICK;
        else if (r < 92)
            cmd = CMD_ADD;
        else if (r < 97)
            cmd = CMD_REMOVE;
        else if (r < 98)
            cmd = CMD_CLEAR;
        else
            cmd = CMD_W'($urandom_range(6, 7));
        if ($urandom_range(0, 9) < 7)
            pid = pid_pool[3'($urandom_range(0, 7))];
        else
            pid = PID_W'($urandom);
        send_cmd(cmd, pid, TAG_W'($urandom), 1'($urandom));
    endtask

    // Drop tvalid and wait until every result has come back, plus the pipeline depth.
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (results_due != 0);
        repeat (4) @(posedge clk);
    endtask

    // Write both registers on consecutive edges, holding cfg_we across them.
    task automatic write_regs(logic [REG_W-1:0] holdoff, logic [REG_W-1:0] resume);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_HOLDOFF;
        cfg_wdata <= holdoff;
        @(posedge clk);
        cfg_addr  <= REG_RESUME;
        cfg_wdata <= resume;
        @(posedge clk);
        cfg_we    <= 1'b0;
        settings_run++;
    endtask

    initial
    begin
        logic [REG_W-1:0] holdoff;
        logic [REG_W-1:0] resume;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: short holdoff and resume so both expire within a few ticks.
        write_regs(10'd2, 10'd3);
        send_cmd(CMD_DISPATCH, 22'd0, 16'd0, 1'b0);        // nothing to dispatch
        send_cmd(CMD_TICK, 22'd0, 16'd0, 1'b0);            // tick with both counters idle
        send_cmd(CMD_SUBMIT, 22'd0, 16'h0000, 1'b0);       // pid 0, lowest tag, normal queue
        send_cmd(CMD_ADD, 22'd0, 16'd0, 1'b0);             // pid 0 is never added
        send_cmd(CMD_ADD, 22'd5, 16'd0, 1'b0);
        send_cmd(CMD_ADD, 22'd5, 16'd0, 1'b0);             // duplicate, ignored
        send_cmd(CMD_ADD, 22'd21, 16'd0, 1'b0);
        send_cmd(CMD_ADD, 22'd37, 16'd0, 1'b0);
        send_cmd(CMD_ADD, 22'd53, 16'd0, 1'b0);            // bucket 5 now full
        send_cmd(CMD_ADD, 22'd69, 16'd0, 1'b0);            // bucket full
        send_cmd(CMD_ADD, 22'h3FFFFF, 16'd0, 1'b0);        // highest pid
        send_cmd(CMD_SUBMIT, 22'h3FFFFF, 16'hFFFF, 1'b0);  // VIP, highest tag
        send_cmd(CMD_SUBMIT, 22'd21, 16'h1234, 1'b0);      // VIP
        send_cmd(CMD_SUBMIT, 22'd1000, 16'h8000, 1'b0);    // normal
        send_cmd(CMD_DISPATCH, 22'd0, 16'd0, 1'b0);        // VIP head, arms holdoff and resume
        send_cmd(CMD_DISPATCH, 22'd0, 16'd0, 1'b0);        // VIP again, rearms both
        send_cmd(CMD_DISPATCH, 22'd0, 16'd0, 1'b0);        // normal held back
        send_cmd(CMD_DISPATCH, 22'd0, 16'd0, 1'b1);        // force past the holdoff
        repeat (3) send_cmd(CMD_TICK, 22'd0, 16'd0, 1'b0); // wake on the third
        send_cmd(CMD_DISPATCH, 22'd0, 16'd0, 1'b0);        // holdoff lapsed, normal served
        send_cmd(CMD_REMOVE, 22'd21, 16'd0, 1'b0);
        send_cmd(CMD_REMOVE, 22'd99, 16'd0, 1'b0);         // absent pid
        send_cmd(3'd6, 22'h3FFFFF, 16'hFFFF, 1'b1);        // unused codes do nothing
        send_cmd(3'd7, 22'h3FFFFF, 16'hFFFF, 1'b1);
        send_cmd(CMD_CLEAR, 22'd0, 16'd0, 1'b0);
        wait_quiet();

        // Fill both queues past depth while the result side holds off for a long stretch,
        // so the block backs up and stalls its input.
        write_regs(10'd0, 10'd1);
        hold_req <= hold_req + 1;
        repeat (QUEUE_DEPTH_DEF + 2)
            send_cmd(CMD_SUBMIT, PID_W'($urandom), TAG_W'($urandom), 1'b0);
        send_cmd(CMD_ADD, 22'd7, 16'd0, 1'b0);
        repeat (QUEUE_DEPTH_DEF + 2) send_cmd(CMD_SUBMIT, 22'd7, TAG_W'($urandom), 1'b0);
        wait_quiet();

        // Random traffic across register settings: both extremes, resume of zero,
        // a random pair, and the reset values with no idling at the end.
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:
                begin
                    holdoff = 10'd0;
                    resume  = 10'd1;
                end
                1:
                begin
                    holdoff = 10'd1023;
                    resume  = 10'd1023;
                end
                2:
                begin
                    holdoff = 10'd7;
                    resume  = 10'd0;
                end
                3:
                begin
                    holdoff = REG_W'($urandom);
                    resume  = REG_W'($urandom_range(1, 1023));
                end
                default:
                begin
                    holdoff = HOLDOFF_RST;
                    resume  = RESUME_RST;
                end
            endcase
            write_regs(holdoff, resume);
            if (ph == 4)
            begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            repeat (PHASE_CMDS) send_random_cmd();
            wait_quiet();
        end

        $display("Ran %0d commands under %0d register settings.", cmds_sent, settings_run);
        $display("Both queues overflowed, a VIP bucket filled, and results stalled for %0d cycles.",
                 LONG_HOLD);
        if (fail_count == 0)
        begin
            $display("vip_priority_request_scheduler_top_test passed");
        end
        else
        begin
            $display("vip_priority_request_scheduler_top_test failed");
        end
        $finish;
    end

    // Run limit, far above the slowest legal run.
    initial
    begin
        #200000;
        $display("vip_priority_request_scheduler_top_test failed");
        $finish;
    end

endmodule
